FILE: rtl/mst_pkg.sv
// Shared types, character codes and note ROMs for the melody tone sequencer.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package mst_pkg;

  localparam int CH_W   = 8;
  localparam int DUR_W  = 24;
  localparam int PER_W  = 17;
  localparam int MULT_W = 8;
  localparam int IDX_W  = 4;
  localparam int OCT_W  = 4;
  localparam int FREQ_W = 9;
  localparam int ROMP_W = 10;
  localparam int PROD_W = MULT_W + FREQ_W;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_A     = 8'h41;
  localparam logic [CH_W-1:0] CH_G     = 8'h47;
  localparam logic [CH_W-1:0] CH_SHARP = 8'h23;
  localparam logic [CH_W-1:0] CH_FLAT  = 8'h62;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_TEMPO = 8'h74;

  localparam logic [IDX_W-1:0]  IDX_MAX       = 4'd11;
  localparam logic [MULT_W-1:0] MULT_RESET    = 8'd2;
  localparam logic [MULT_W-1:0] TEMPO_RESET   = 8'd12;
  localparam logic [PER_W-1:0]  PERIOD_BIAS   = 17'd30;
  localparam logic [DUR_W-1:0]  DUR_FULL      = 24'hFFFFFF;

  // Register addresses (byte address 4*i)
  localparam logic REG_MODEL_ONE = 1'b0;

  // Note operands captured when a pending note is emitted
  typedef struct packed {
    logic [MULT_W-1:0]       mult;
    logic [IDX_W-1:0]        idx;
    logic signed [OCT_W-1:0] oct;
    logic [MULT_W-1:0]       tempo;
  } note_ops_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic last;
  } div_sts_t;

  function automatic logic [IDX_W-1:0] letter_index(input logic [2:0] ofs);
    logic [IDX_W-1:0] r;
    case (ofs)
      3'd0:    r = 4'd9;
      3'd1:    r = 4'd11;
      3'd2:    r = 4'd0;
      3'd3:    r = 4'd2;
      3'd4:    r = 4'd4;
      3'd5:    r = 4'd5;
      3'd6:    r = 4'd7;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  function automatic logic [FREQ_W-1:0] rom_freq(input logic [IDX_W-1:0] idx);
    logic [FREQ_W-1:0] r;
    case (idx)
      4'd0:    r = 9'd262;
      4'd1:    r = 9'd277;
      4'd2:    r = 9'd294;
      4'd3:    r = 9'd311;
      4'd4:    r = 9'd330;
      4'd5:    r = 9'd349;
      4'd6:    r = 9'd370;
      4'd7:    r = 9'd392;
      4'd8:    r = 9'd415;
      4'd9:    r = 9'd440;
      4'd10:   r = 9'd466;
      default: r = 9'd494;
    endcase
    return r;
  endfunction

  function automatic logic [ROMP_W-1:0] rom_per1(input logic [IDX_W-1:0] idx);
    logic [ROMP_W-1:0] r;
    case (idx)
      4'd0:    r = 10'd848;
      4'd1:    r = 10'd800;
      4'd2:    r = 10'd755;
      4'd3:    r = 10'd713;
      4'd4:    r = 10'd673;
      4'd5:    r = 10'd635;
      4'd6:    r = 10'd599;
      4'd7:    r = 10'd566;
      4'd8:    r = 10'd534;
      4'd9:    r = 10'd504;
      4'd10:   r = 10'd476;
      default: r = 10'd449;
    endcase
    return r;
  endfunction

  function automatic logic [ROMP_W-1:0] rom_per3(input logic [IDX_W-1:0] idx);
    logic [ROMP_W-1:0] r;
    case (idx)
      4'd0:    r = 10'd983;
      4'd1:    r = 10'd928;
      4'd2:    r = 10'd876;
      4'd3:    r = 10'd827;
      4'd4:    r = 10'd780;
      4'd5:    r = 10'd737;
      4'd6:    r = 10'd695;
      4'd7:    r = 10'd656;
      4'd8:    r = 10'd619;
      4'd9:    r = 10'd585;
      4'd10:   r = 10'd552;
      default: r = 10'd521;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mst_stream_if.sv
// Valid/ready channel interfaces: melody characters in, tone requests out.
// Depends on mst_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mst_in_if;
  logic                      valid;
  logic                      ready;
  logic [mst_pkg::CH_W-1:0]  ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface mst_out_if;
  logic                      valid;
  logic                      ready;
  logic [mst_pkg::DUR_W-1:0] tone_duration;
  logic [mst_pkg::PER_W-1:0] tone_period;
  logic                      bad_tempo;
  modport source (output valid, output tone_duration, output tone_period,
                  output bad_tempo, input ready);
  modport sink   (input valid, input tone_duration, input tone_period,
                  input bad_tempo, output ready);
endinterface
`default_nettype wire

FILE: rtl/mst_parser.sv
// Character decoder and melody state (note, multiplier, digits, tempo, octave).
// Depends on mst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mst_parser #(
  parameter int OCTAVE_LIMIT = 7
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        take,
  input  wire logic [mst_pkg::CH_W-1:0]    ch,
  output logic                             emit,
  output mst_pkg::note_ops_t               ops
);

  localparam logic signed [mst_pkg::OCT_W-1:0] OCT_HI = mst_pkg::OCT_W'(OCTAVE_LIMIT);
  localparam logic signed [mst_pkg::OCT_W-1:0] OCT_LO = mst_pkg::OCT_W'(-OCTAVE_LIMIT);

  logic                              pending_r;
  logic [mst_pkg::IDX_W-1:0]         idx_r;
  logic [mst_pkg::MULT_W-1:0]        mult_r;
  logic [mst_pkg::MULT_W-1:0]        digits_r;
  logic [mst_pkg::MULT_W-1:0]        tempo_r;
  logic signed [mst_pkg::OCT_W-1:0]  oct_r;

  logic                              is_letter;
  logic                              is_nul;
  logic                              is_digit;
  logic [2:0]                        letter_ofs;
  logic [mst_pkg::CH_W-1:0]          digit_val;
  logic [mst_pkg::MULT_W-1:0]        digits_nxt;

  assign is_letter  = (ch >= mst_pkg::CH_A) && (ch <= mst_pkg::CH_G);
  assign is_nul     = (ch == mst_pkg::CH_NUL);
  assign is_digit   = (ch >= mst_pkg::CH_ZERO) && (ch <= mst_pkg::CH_NINE);
  assign letter_ofs = 3'(ch - mst_pkg::CH_A);
  assign digit_val  = ch - mst_pkg::CH_ZERO;
  // 10*x + d, wrapping at 8 bits
  assign digits_nxt = {digits_r[4:0], 3'b000} + {digits_r[6:0], 1'b0} + digit_val;

  assign emit = (is_letter || is_nul) && pending_r;

  always_comb begin
    ops.mult  = (digits_r != '0) ? digits_r : mult_r;
    ops.idx   = (idx_r > mst_pkg::IDX_MAX) ? mst_pkg::IDX_MAX : idx_r;
    ops.oct   = oct_r;
    ops.tempo = tempo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      idx_r     <= '0;
      mult_r    <= mst_pkg::MULT_RESET;
      digits_r  <= '0;
      tempo_r   <= mst_pkg::TEMPO_RESET;
      oct_r     <= '0;
    end else if (take) begin
      if (is_nul) begin
        pending_r <= 1'b0;
        idx_r     <= '0;
        mult_r    <= mst_pkg::MULT_RESET;
        digits_r  <= '0;
        tempo_r   <= mst_pkg::TEMPO_RESET;
        oct_r     <= '0;
      end else if (is_letter) begin
        if (emit && digits_r != '0) begin
          mult_r   <= digits_r;
          digits_r <= '0;
        end
        idx_r     <= mst_pkg::letter_index(letter_ofs);
        pending_r <= 1'b1;
      end else if (is_digit) begin
        digits_r <= digits_nxt;
      end else begin
        case (ch)
          mst_pkg::CH_SHARP: begin
            if (pending_r && idx_r < mst_pkg::IDX_MAX) idx_r <= idx_r + 1'b1;
          end
          mst_pkg::CH_FLAT: begin
            if (pending_r && idx_r > '0) idx_r <= idx_r - 1'b1;
          end
          mst_pkg::CH_PLUS: begin
            if (oct_r < OCT_HI) oct_r <= oct_r + 1'b1;
          end
          mst_pkg::CH_MINUS: begin
            if (oct_r > OCT_LO) oct_r <= oct_r - 1'b1;
          end
          mst_pkg::CH_TEMPO: begin
            tempo_r  <= digits_r;
            digits_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mst_divider.sv
// Restoring divider, one quotient bit per cycle: 24-bit dividend by 8-bit divisor.
// Depends on mst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mst_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mst_pkg::div_ctl_t             ctl,
  input  wire logic [mst_pkg::DUR_W-1:0]     dividend,
  input  wire logic [mst_pkg::MULT_W-1:0]    divisor,
  output mst_pkg::div_sts_t                  sts,
  output logic [mst_pkg::DUR_W-1:0]          quotient
);

  localparam int                 STEPS = mst_pkg::DUR_W;
  localparam int                 CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0]   LAST  = CNT_W'(STEPS - 1);

  logic                           busy_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [mst_pkg::MULT_W-1:0]     dsr_r;
  logic [mst_pkg::MULT_W-1:0]     rem_r;
  logic [mst_pkg::DUR_W-1:0]      quo_r;

  logic [mst_pkg::MULT_W:0]       trial;
  logic                           fits;
  logic [mst_pkg::MULT_W:0]       diff;
  logic [mst_pkg::MULT_W-1:0]     rem_nxt;
  logic [mst_pkg::DUR_W-1:0]      quo_nxt;

  // remainder stays below the divisor, so 8 bits plus the incoming bit suffice
  assign trial   = {rem_r, quo_r[mst_pkg::DUR_W-1]};
  assign fits    = trial >= {1'b0, dsr_r};
  assign diff    = trial - {1'b0, dsr_r};
  assign rem_nxt = fits ? diff[mst_pkg::MULT_W-1:0] : trial[mst_pkg::MULT_W-1:0];
  assign quo_nxt = {quo_r[mst_pkg::DUR_W-2:0], fits};

  assign sts.last = busy_r && (cnt_r == LAST);
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/melody_string_tone_sequencer.sv
// Melody string tone sequencer: top level with sequencer, operand datapath and APB register.
// Depends on mst_pkg, mst_stream_if, mst_parser and mst_divider.
//
// Characters arrive one request at a time on in_ch. A character that does not
// release a pending note is absorbed without stalling in_ch. A letter or NUL that
// releases a note captures the note operands at its accepting edge and then holds
// in_ch.ready low through the states S_MUL (the 8x9 multiply and octave shifts),
// S_DIV (the bit-serial restoring divider that forms duration / tempo) and S_OUT
// (the hand-off of the tone to the output register); a zero tempo skips S_DIV.
// The tone request then sits in the out_tone register until taken, while new
// characters are accepted; a further tone waits in S_OUT if the previous one has
// not been taken.
// The single register model_one_timing sits at byte address 0; the user must write
// it only while the block is idle, since the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module melody_string_tone_sequencer #(
  parameter int OCTAVE_LIMIT = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mst_in_if.sink           in_ch,
  mst_out_if.source        out_tone,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_t;

  state_t                          state_r;
  logic                            model_one_r;
  mst_pkg::note_ops_t              ops_r;
  logic [mst_pkg::PER_W-1:0]       per_r;
  logic                            bad_r;
  logic                            out_valid_r;
  logic [mst_pkg::DUR_W-1:0]       out_dur_r;
  logic [mst_pkg::PER_W-1:0]       out_per_r;
  logic                            out_bad_r;

  logic                            take;
  logic                            emit;
  mst_pkg::note_ops_t              ops;
  mst_pkg::div_ctl_t               div_ctl;
  mst_pkg::div_sts_t               div_sts;
  logic [mst_pkg::DUR_W-1:0]       quotient;

  logic [mst_pkg::PROD_W-1:0]      prod;
  logic [mst_pkg::ROMP_W-1:0]      rom_per;
  logic [2:0]                      sh;
  logic [mst_pkg::DUR_W-1:0]       prod_ext;
  logic [mst_pkg::PER_W-1:0]       per_ext;
  logic [mst_pkg::DUR_W-1:0]       dividend_nxt;
  logic [mst_pkg::PER_W-1:0]       shifted_per;
  logic [mst_pkg::PER_W-1:0]       per_nxt;
  logic                            out_free;
  logic                            wr_en;

  // APB register
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == mst_pkg::REG_MODEL_ONE) ? {31'b0, model_one_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_one_r <= 1'b0;
    end else if (wr_en && paddr[2] == mst_pkg::REG_MODEL_ONE) begin
      model_one_r <= pwdata[0];
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign take        = in_ch.valid && in_ch.ready;

  mst_parser #(
    .OCTAVE_LIMIT (OCTAVE_LIMIT)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .ch    (in_ch.ch),
    .emit  (emit),
    .ops   (ops)
  );

  // Multiply and octave shift, from captured operands
  assign prod     = ops_r.mult * mst_pkg::rom_freq(ops_r.idx);
  assign rom_per  = model_one_r ? mst_pkg::rom_per1(ops_r.idx) : mst_pkg::rom_per3(ops_r.idx);
  assign sh       = ops_r.oct[mst_pkg::OCT_W-1] ? 3'(-ops_r.oct) : ops_r.oct[2:0];
  assign prod_ext = mst_pkg::DUR_W'(prod);
  assign per_ext  = mst_pkg::PER_W'(rom_per);

  always_comb begin
    if (ops_r.oct[mst_pkg::OCT_W-1]) begin
      dividend_nxt = prod_ext >> sh;
      shifted_per  = per_ext << sh;
    end else begin
      dividend_nxt = prod_ext << sh;
      shifted_per  = per_ext >> sh;
    end
    per_nxt = (shifted_per < mst_pkg::PERIOD_BIAS) ? '0 : shifted_per - mst_pkg::PERIOD_BIAS;
  end

  assign div_ctl.start = (state_r == S_MUL) && (ops_r.tempo != '0);

  mst_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (dividend_nxt),
    .divisor  (ops_r.tempo),
    .sts      (div_sts),
    .quotient (quotient)
  );

  assign out_free = !out_valid_r || out_tone.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tone.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (take && emit) state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= (ops_r.tempo == '0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (div_sts.last) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_dur_r <= bad_r ? mst_pkg::DUR_FULL : quotient;
            out_per_r <= per_r;
            out_bad_r <= bad_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (take && emit) ops_r <= ops;
    if (state_r == S_MUL) begin
      per_r <= per_nxt;
      bad_r <= (ops_r.tempo == '0);
    end
  end

  assign out_tone.valid         = out_valid_r;
  assign out_tone.tone_duration = out_dur_r;
  assign out_tone.tone_period   = out_per_r;
  assign out_tone.bad_tempo     = out_bad_r;

endmodule
`default_nettype wire

FILE: tb/melody_string_tone_sequencer_test.sv
// Self-checking testbench for melody_string_tone_sequencer: character stream in, tones out.
// Depends on mst_pkg, the mst_in_if/mst_out_if interfaces and the RTL top level.
`timescale 1ns / 1ps
module melody_string_tone_sequencer_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int OCT_LIMIT   = 7;
  localparam int DRAIN_WAIT  = 40;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [mst_pkg::DUR_W-1:0] duration;
    logic [mst_pkg::PER_W-1:0] period;
    logic                      bad;
  } tone_t;

  // Tone predictor plus queue of tones still owed by the block.
  class tone_scoreboard;
    tone_t                            expected_tones[$];
    int                               errors;
    int                               tones_checked;
    int                               zero_tempo_tones;
    int                               clamped_tones;
    logic                             model_one;
    logic                             note_pending;
    logic [mst_pkg::IDX_W-1:0]        note_idx;
    logic [mst_pkg::MULT_W-1:0]       mult;
    logic [mst_pkg::MULT_W-1:0]       digits;
    logic [mst_pkg::MULT_W-1:0]       tempo;
    logic signed [mst_pkg::OCT_W-1:0] octave;
    int unsigned                      freq_tab[12];
    int unsigned                      per1_tab[12];
    int unsigned                      per3_tab[12];
    int unsigned                      letter_map[7];

    function new();
      freq_tab   = '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494};
      per1_tab   = '{848, 800, 755, 713, 673, 635, 599, 566, 534, 504, 476, 449};
      per3_tab   = '{983, 928, 876, 827, 780, 737, 695, 656, 619, 585, 552, 521};
      letter_map = '{9, 11, 0, 2, 4, 5, 7};
      errors = 0;
      tones_checked = 0;
      zero_tempo_tones = 0;
      clamped_tones = 0;
      model_one = 1'b0;
      clear_melody();
    endfunction

    function void clear_melody();
      note_pending = 1'b0;
      note_idx = '0;
      mult = mst_pkg::MULT_RESET;
      digits = '0;
      tempo = mst_pkg::TEMPO_RESET;
      octave = '0;
    endfunction

    function void set_timing(logic v);
      model_one = v;
    endfunction

    function int pending();
      return expected_tones.size();
    endfunction

    function void emit_tone();
      tone_t       t;
      int unsigned a;
      int unsigned b;
      int          sh;
      int          per;
      if (digits != 0) begin
        mult = digits;
        digits = '0;
      end
      a = int'(mult) * freq_tab[note_idx];
      b = model_one ? per1_tab[note_idx] : per3_tab[note_idx];
      // positive octave raises pitch: longer count, shorter period
      if (int'(octave) >= 0) begin
        sh = int'(octave);
        a = a << sh;
        b = b >> sh;
      end else begin
        sh = -int'(octave);
        a = a >> sh;
        b = b << sh;
      end
      if (tempo == 0) begin
        t.duration = mst_pkg::DUR_FULL;
        t.bad = 1'b1;
      end else begin
        t.duration = mst_pkg::DUR_W'(a / int'(tempo));
        t.bad = 1'b0;
      end
      per = int'(b) - int'(mst_pkg::PERIOD_BIAS);
      t.period = (per < 0) ? '0 : mst_pkg::PER_W'(per);
      expected_tones.push_back(t);
    endfunction

    function void note_char(logic [mst_pkg::CH_W-1:0] c);
      if ((c >= mst_pkg::CH_A && c <= mst_pkg::CH_G) || c == mst_pkg::CH_NUL) begin
        if (note_pending) emit_tone();
        if (c == mst_pkg::CH_NUL) begin
          clear_melody();
        end else begin
          note_idx = mst_pkg::IDX_W'(letter_map[c - mst_pkg::CH_A]);
          note_pending = 1'b1;
        end
      end else if (c == mst_pkg::CH_SHARP) begin
        if (note_pending && note_idx < mst_pkg::IDX_MAX) note_idx = note_idx + 1'b1;
      end else if (c == mst_pkg::CH_FLAT) begin
        if (note_pending && note_idx > 0) note_idx = note_idx - 1'b1;
      end else if (c == mst_pkg::CH_PLUS) begin
        if (int'(octave) < OCT_LIMIT) octave = octave + 1'b1;
      end else if (c == mst_pkg::CH_MINUS) begin
        if (int'(octave) > -OCT_LIMIT) octave = octave - 1'b1;
      end else if (c >= mst_pkg::CH_ZERO && c <= mst_pkg::CH_NINE) begin
        digits = mst_pkg::MULT_W'(10 * int'(digits) + int'(c - mst_pkg::CH_ZERO));
      end else if (c == mst_pkg::CH_TEMPO) begin
        tempo = digits;
        digits = '0;
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_tone(tone_t got);
      tone_t want;
      if (expected_tones.size() == 0) begin
        report_mismatch($sformatf("unexpected tone dur=%0d per=%0d bad=%0b",
                                  got.duration, got.period, got.bad));
      end else begin
        want = expected_tones.pop_front();
        tones_checked++;
        if (want.bad) zero_tempo_tones++;
        if (want.period == 0) clamped_tones++;
        if (got.duration !== want.duration)
          report_mismatch($sformatf("tone %0d duration %0d, want %0d",
                                    tones_checked, got.duration, want.duration));
        if (got.period !== want.period)
          report_mismatch($sformatf("tone %0d period %0d, want %0d",
                                    tones_checked, got.period, want.period));
        if (got.bad !== want.bad)
          report_mismatch($sformatf("tone %0d bad_tempo %0b, want %0b",
                                    tones_checked, got.bad, want.bad));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mst_in_if  in_if ();
  mst_out_if out_if ();

  tone_scoreboard sb = new();

  int cycle_count = 0;
  int hold_cycles = 0;
  int burst_left = 0;
  int chars_sent = 0;
  bit no_gaps = 1'b0;

  melody_string_tone_sequencer #(.OCTAVE_LIMIT(OCT_LIMIT)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_tone(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[melody_string_tone_sequencer] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_tone('{out_if.tone_duration, out_if.tone_period, out_if.bad_tempo});
  end

  // Result side: random stall patterns in stretches, plus the long hold-off on request.
  initial begin
    int stretch;
    int mode;
    stretch = 0;
    mode = 0;
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 3);
          stretch = $urandom_range(10, 150);
        end
        stretch--;
        case (mode)
          0:       out_if.ready = 1'b1;
          1:       out_if.ready = 1'($urandom_range(0, 1));
          2:       out_if.ready = (stretch % 4 == 0);
          default: out_if.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_char(input logic [mst_pkg::CH_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.ch = c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_char(c);
    burst_left--;
    chars_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_if.valid = 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = 3'(mst_pkg::REG_MODEL_ONE) << 2;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (!wr && prdata !== data)
      sb.report_mismatch($sformatf("model_one_timing reads %0h, want %0h", prdata, data));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Block must be idle: every tone out, then margin for any late work.
  task automatic set_timing(input logic v);
    idle_input();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    reg_access(1'b1, {31'b0, v});
    sb.set_timing(v);
    reg_access(1'b0, {31'b0, v});
  endtask

  task automatic play_directed();
    logic [mst_pkg::CH_W-1:0] seq [27];
    seq = '{mst_pkg::CH_SHARP,                 // semitone with no note: ignored
            mst_pkg::CH_A + 8'd2,
            mst_pkg::CH_FLAT, mst_pkg::CH_FLAT, // flat saturates at the bottom
            mst_pkg::CH_A + 8'd3,
            mst_pkg::CH_A + 8'd1, mst_pkg::CH_SHARP, // sharp saturates at the top
            mst_pkg::CH_ZERO, mst_pkg::CH_TEMPO, // zero tempo
            mst_pkg::CH_A + 8'd4,
            mst_pkg::CH_PLUS, mst_pkg::CH_PLUS, mst_pkg::CH_PLUS, mst_pkg::CH_PLUS,
            mst_pkg::CH_PLUS, mst_pkg::CH_PLUS, mst_pkg::CH_PLUS,
            mst_pkg::CH_PLUS,                  // octave saturates high
            mst_pkg::CH_NINE, mst_pkg::CH_NINE,
            mst_pkg::CH_NINE,                  // digits wrap past 255
            mst_pkg::CH_A + 8'd5,              // high octave: period clamps to zero
            8'hFF,                             // unused code
            mst_pkg::CH_MINUS,
            mst_pkg::CH_A, mst_pkg::CH_G,
            mst_pkg::CH_NUL};
    foreach (seq[i]) send_char(seq[i]);
  endtask

  // Mostly well-formed melodies with random content, some raw noise bytes.
  task automatic play_random(input int n_items);
    int stop_at;
    int n;
    logic [mst_pkg::CH_W-1:0] step;
    stop_at = chars_sent + n_items;
    while (chars_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_char(mst_pkg::CH_W'($urandom_range(0, 255)));
        continue;
      end
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          send_char(mst_pkg::CH_ZERO);
        end else begin
          n = $urandom_range(1, 3);
          repeat (n) send_char(mst_pkg::CH_ZERO + mst_pkg::CH_W'($urandom_range(0, 9)));
        end
        send_char(mst_pkg::CH_TEMPO);
      end
      if ($urandom_range(0, 3) == 0) begin
        step = $urandom_range(0, 1) ? mst_pkg::CH_PLUS : mst_pkg::CH_MINUS;
        n = $urandom_range(1, 9);
        repeat (n) send_char(step);
      end
      send_char(mst_pkg::CH_A + mst_pkg::CH_W'($urandom_range(0, 6)));
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) send_char($urandom_range(0, 1) ? mst_pkg::CH_SHARP : mst_pkg::CH_FLAT);
      end
      if ($urandom_range(0, 1) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) send_char(mst_pkg::CH_ZERO + mst_pkg::CH_W'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 11) == 0) send_char(mst_pkg::CH_NUL);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.ch = mst_pkg::CH_NUL;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    reg_access(1'b0, 32'd0);
    play_directed();

    for (int phase = 0; phase < 4; phase++) begin
      set_timing(phase % 2 == 0);
      if (phase == 2) begin
        // stall the result side long enough for the block to back up its input
        @(posedge clk);
        hold_cycles = LONG_HOLD;
        no_gaps = 1'b1;
        play_random(120);
        no_gaps = 1'b0;
        play_random(280);
      end else if (phase == 1) begin
        play_random(200);
        idle_input();
        wait_drained();
        play_random(200);
      end else begin
        play_random(400);
      end
    end

    idle_input();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d characters, %0d tones checked under both period columns",
             chars_sent, sb.tones_checked);
    $display("%0d tones at zero tempo, %0d with clamped period, %0d mismatches",
             sb.zero_tempo_tones, sb.clamped_tones, sb.errors);
    if (sb.errors == 0) begin
      $display("[melody_string_tone_sequencer] OK");
    end else begin
      $display("[melody_string_tone_sequencer] ERROR");
    end
    $finish;
  end

endmodule
